// File: hw/rtl/sector_buffer_cache_lfu_macros.svh
// Assertion macros used by the sector buffer cache top module.
// All of them sample on the rising edge of clock and are off while reset is high.
`ifndef SECTOR_BUFFER_CACHE_LFU_MACROS_SVH
`define SECTOR_BUFFER_CACHE_LFU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hw/rtl/sbc_pkg.sv
package sbc_pkg;

   localparam int SLOTS_DEF   = 16;
   localparam int MAX_RUN_DEF = 128;

   localparam int SECTOR_W = 32;
   localparam int COUNT_W  = 8;
   localparam int USES_W   = 16;
   localparam int SLOT_W   = 4;

   localparam logic [USES_W-1:0] USES_MAX = {USES_W{1'b1}};

   typedef enum logic [1:0] {
      WR_CLEAR = 2'd0,
      WR_HIT   = 2'd1,
      WR_MISS  = 2'd2
   } wr_kind_type;

   // Scan token that walks down the row of slot cells.
   typedef struct packed {
      logic                valid;
      logic                done;
      logic                hit;
      logic                need_fill;
      logic                have_victim;
      logic [USES_W-1:0]   vuses;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
   } tok_type;

   // Update broadcast to all cells; only the addressed cell takes it.
   typedef struct packed {
      logic                en;
      wr_kind_type         kind;
      logic                set_count;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
   } wr_type;

endpackage

// File: hw/rtl/sbc_cell.sv
module sbc_cell #(
   parameter int SLOTS = sbc_pkg::SLOTS_DEF,
   parameter int INDEX = 0,
   localparam int IDXW = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  sbc_pkg::tok_type  tok_i,
   input  logic [IDXW-1:0]   idx_i,
   output sbc_pkg::tok_type  tok_o,
   output logic [IDXW-1:0]   idx_o,
   input  sbc_pkg::wr_type   wr_i,
   input  logic [IDXW-1:0]   wr_idx_i
);

   localparam logic [IDXW-1:0] MY_IDX = IDXW'(INDEX);

   logic [sbc_pkg::SECTOR_W-1:0] sector_ff;
   logic [sbc_pkg::USES_W-1:0]   uses_ff;
   logic [sbc_pkg::COUNT_W-1:0]  count_ff;
   sbc_pkg::tok_type             tok_ff, tok_in;
   logic [IDXW-1:0]              idx_ff, idx_in;
   logic                         match;
   logic                         take;
   logic                         sel;

   assign match = (sector_ff == tok_i.sector);
   assign sel   = wr_i.en && (wr_idx_i == MY_IDX);

   always_comb begin
      tok_in = tok_i;
      idx_in = idx_i;
      take   = !tok_i.have_victim || (tok_i.vuses > uses_ff);
      if (tok_i.valid && !tok_i.done) begin
         if (match) begin
            tok_in.done      = 1'b1;
            tok_in.hit       = 1'b1;
            tok_in.need_fill = (count_ff < tok_i.count);
            idx_in           = MY_IDX;
         end else begin
            if (take) begin
               tok_in.have_victim = 1'b1;
               tok_in.vuses       = uses_ff;
               idx_in             = MY_IDX;
            end
            // An unused slot ends the scan: it is the victim and nothing later counts.
            if (take && (uses_ff == '0)) begin
               tok_in.done = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sector_ff <= '0;
         uses_ff   <= '0;
         count_ff  <= '0;
      end else if (sel) begin
         case (wr_i.kind)
            sbc_pkg::WR_CLEAR: begin
               sector_ff <= '0;
               uses_ff   <= '0;
               count_ff  <= '0;
            end
            sbc_pkg::WR_HIT: begin
               if (uses_ff != sbc_pkg::USES_MAX) begin
                  uses_ff <= uses_ff + 1'b1;
               end
               if (wr_i.set_count) begin
                  count_ff <= wr_i.count;
               end
            end
            sbc_pkg::WR_MISS: begin
               sector_ff <= wr_i.sector;
               uses_ff   <= sbc_pkg::USES_W'(1);
               count_ff  <= wr_i.count;
            end
            default: begin
            end
         endcase
      end
   end

   assign tok_o = tok_ff;
   assign idx_o = idx_ff;

endmodule

// File: hw/rtl/sector_buffer_cache_lfu.sv
// Tag store of a sector buffer cache with least-used replacement. A lookup transaction
// is taken when start is high and busy is low; a scan token then passes down a row of
// SLOTS slot cells, one cell per clock, and busy stays high until the token leaves the
// last cell, whose output is registered once more to give the result. A fill-failed
// report does not raise busy. Each result is shown for exactly one cycle with
// rsp_valid high; the receiver cannot stall it and must take it in that cycle.
`include "sector_buffer_cache_lfu_macros.svh"

module sector_buffer_cache_lfu #(
   parameter int SLOTS   = sbc_pkg::SLOTS_DEF,
   parameter int MAX_RUN = sbc_pkg::MAX_RUN_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic                         req_operation,
   input  logic [sbc_pkg::SECTOR_W-1:0] req_sector,
   input  logic [sbc_pkg::COUNT_W-1:0]  req_count,
   input  logic [sbc_pkg::SLOT_W-1:0]   req_failed_slot,
   output logic                         rsp_valid,
   output logic [sbc_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_need_fill,
   output logic                         rsp_hit
);

   localparam int IDXW = $clog2(SLOTS);
   localparam logic [sbc_pkg::COUNT_W-1:0] RUN_LIMIT = sbc_pkg::COUNT_W'(MAX_RUN);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type                     state_ff, state_in;
   sbc_pkg::tok_type              launch;
   sbc_pkg::tok_type              tok [SLOTS];
   logic [IDXW-1:0]               idx [SLOTS];
   logic [SLOTS-1:0]              tok_valid_vec;
   sbc_pkg::tok_type              last;
   logic [IDXW-1:0]               last_idx;
   logic                          last_valid;
   logic                          tok_active;
   logic                          accept;
   logic                          lookup_accept;
   logic                          fail_accept;
   logic                          fslot_ok;
   logic [sbc_pkg::COUNT_W-1:0]   count_clamped;
   sbc_pkg::wr_type               wr;
   logic [IDXW-1:0]               wr_idx;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sbc_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic                          rsp_need_fill_ff, rsp_need_fill_in;
   logic                          rsp_hit_ff, rsp_hit_in;

   assign busy          = reset || (state_ff != ST_IDLE);
   assign accept        = start && !busy;
   assign lookup_accept = accept && !req_operation;
   assign fail_accept   = accept && req_operation;
   assign fslot_ok      = int'(req_failed_slot) < SLOTS;

   always_comb begin
      if (req_count == '0) begin
         count_clamped = sbc_pkg::COUNT_W'(1);
      end else if (req_count > RUN_LIMIT) begin
         count_clamped = RUN_LIMIT;
      end else begin
         count_clamped = req_count;
      end
   end

   always_comb begin
      launch        = '0;
      launch.valid  = lookup_accept;
      launch.sector = req_sector;
      launch.count  = count_clamped;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      if (i == 0) begin : g_first
         sbc_cell #(.SLOTS(SLOTS), .INDEX(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_i    (launch),
            .idx_i    ('0),
            .tok_o    (tok[i]),
            .idx_o    (idx[i]),
            .wr_i     (wr),
            .wr_idx_i (wr_idx)
         );
      end else begin : g_next
         sbc_cell #(.SLOTS(SLOTS), .INDEX(i)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .tok_i    (tok[i-1]),
            .idx_i    (idx[i-1]),
            .tok_o    (tok[i]),
            .idx_o    (idx[i]),
            .wr_i     (wr),
            .wr_idx_i (wr_idx)
         );
      end
      assign tok_valid_vec[i] = tok[i].valid;
   end

   assign last       = tok[SLOTS-1];
   assign last_idx   = idx[SLOTS-1];
   assign last_valid = last.valid;
   assign tok_active = |tok_valid_vec;

   always_comb begin
      wr     = '0;
      wr_idx = last_idx;
      if (fail_accept && fslot_ok) begin
         wr.en   = 1'b1;
         wr.kind = sbc_pkg::WR_CLEAR;
         wr_idx  = IDXW'(req_failed_slot);
      end else if (last_valid) begin
         wr.en        = 1'b1;
         wr.kind      = last.hit ? sbc_pkg::WR_HIT : sbc_pkg::WR_MISS;
         wr.set_count = last.need_fill;
         wr.sector    = last.sector;
         wr.count     = last.count;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (lookup_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_valid) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in     = fail_accept || last_valid;
      rsp_slot_in      = sbc_pkg::SLOT_W'(last_idx);
      rsp_need_fill_in = last.hit ? last.need_fill : 1'b1;
      rsp_hit_in       = last.hit;
      if (fail_accept) begin
         rsp_slot_in      = req_failed_slot;
         rsp_need_fill_in = 1'b0;
         rsp_hit_in       = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_slot_ff      <= rsp_slot_in;
      rsp_need_fill_ff <= rsp_need_fill_in;
      rsp_hit_ff       <= rsp_hit_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_slot      = rsp_slot_ff;
   assign rsp_need_fill = rsp_need_fill_ff;
   assign rsp_hit       = rsp_hit_ff;

   `SBC_ASSERT_NOW(a_one_token, 1'b1, $onehot0(tok_valid_vec), "two scan tokens in the row")
   `SBC_ASSERT_NOW(a_token_in_scan, tok_active, state_ff == ST_SCAN, "token outside a lookup")
   `SBC_ASSERT_NEXT(a_rsp_after_scan, last_valid, rsp_valid_ff, "finished scan gave no result")
   `SBC_ASSERT_NOW(a_rsp_cause, rsp_valid_ff, $past(last_valid || fail_accept), "stray result")

endmodule

// File: sim/tb_sector_buffer_cache_lfu.sv
`timescale 1ns / 100ps

module tb_sector_buffer_cache_lfu;
   import sbc_pkg::*;

   localparam int SLOTS         = SLOTS_DEF;
   localparam int MAX_RUN       = MAX_RUN_DEF;
   localparam int RANDOM_ITEMS  = 540;
   localparam int REPEAT_HITS   = 40;
   localparam int POOL_SIZE     = 24;
   localparam int REPORT_LIMIT  = 10;

   typedef enum logic {
      OP_LOOKUP      = 1'b0,
      OP_FILL_FAILED = 1'b1
   } cache_op_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic              need_fill;
      logic              hit;
   } answer_type;

   typedef struct packed {
      cache_op_type        op;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0]  count;
      logic [SLOT_W-1:0]   failed_slot;
      logic                typed;
      answer_type          answer;
   } step_row_type;

   logic                clock = 1'b0;
   logic                reset;
   logic                start;
   logic                busy;
   logic                req_operation;
   logic [SECTOR_W-1:0] req_sector;
   logic [COUNT_W-1:0]  req_count;
   logic [SLOT_W-1:0]   req_failed_slot;
   logic                rsp_valid;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_need_fill;
   logic                rsp_hit;

   // Mirror of the tag store.
   logic [SECTOR_W-1:0] mirror_tag  [SLOTS];
   logic [USES_W-1:0]   mirror_uses [SLOTS];
   logic [COUNT_W-1:0]  mirror_len  [SLOTS];

   answer_type          pending_answers [$];
   logic [SECTOR_W-1:0] sector_pool [POOL_SIZE];

   int mismatch_count  = 0;
   int answers_checked = 0;
   int full_hits       = 0;
   int short_hits      = 0;
   int misses          = 0;
   int fill_reports    = 0;

   // The directed rows run from reset, when every slot holds tag 0 with no uses.
   step_row_type directed_steps [26] = '{
      '{OP_LOOKUP,      32'h0000_0000, 8'd4,   4'd0,  1'b1, '{4'd0,  1'b1, 1'b1}},
      '{OP_LOOKUP,      32'h0000_0000, 8'd4,   4'd0,  1'b1, '{4'd0,  1'b0, 1'b1}},
      '{OP_LOOKUP,      32'hFFFF_FFFF, 8'd128, 4'd0,  1'b1, '{4'd1,  1'b1, 1'b0}},
      '{OP_LOOKUP,      32'hFFFF_FFFF, 8'd0,   4'd0,  1'b1, '{4'd1,  1'b0, 1'b1}},
      '{OP_LOOKUP,      32'hFFFF_FFFF, 8'd255, 4'd0,  1'b1, '{4'd1,  1'b0, 1'b1}},
      '{OP_LOOKUP,      32'h1234_5678, 8'd200, 4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'hA5A5_A5A5, 8'd129, 4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h5A5A_5A5A, 8'd1,   4'd0,  1'b0, '0},
      '{OP_FILL_FAILED, 32'h0000_0000, 8'd1,   4'd2,  1'b1, '{4'd2,  1'b0, 1'b0}},
      // Slot 2 now has no uses, so the scan stops there before reaching slot 3.
      '{OP_LOOKUP,      32'hA5A5_A5A5, 8'd1,   4'd0,  1'b0, '0},
      '{OP_FILL_FAILED, 32'h0000_0000, 8'd0,   4'd15, 1'b1, '{4'd15, 1'b0, 1'b0}},
      '{OP_FILL_FAILED, 32'hFFFF_FFFF, 8'd255, 4'd0,  1'b1, '{4'd0,  1'b0, 1'b0}},
      '{OP_LOOKUP,      32'h0000_0000, 8'd2,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h5A5A_5A5A, 8'd129, 4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0100, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0101, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0102, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0103, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0104, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0105, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0106, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0107, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0108, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_0109, 8'd8,   4'd0,  1'b0, '0},
      '{OP_LOOKUP,      32'h0000_010A, 8'd8,   4'd0,  1'b0, '0},
      // Every slot is in use here, so this miss must evict the first least-used slot.
      '{OP_LOOKUP,      32'h8000_0000, 8'd64,  4'd0,  1'b0, '0}
   };

   sector_buffer_cache_lfu #(
      .SLOTS   (SLOTS),
      .MAX_RUN (MAX_RUN)
   ) dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_sector      (req_sector),
      .req_count       (req_count),
      .req_failed_slot (req_failed_slot),
      .rsp_valid       (rsp_valid),
      .rsp_slot        (rsp_slot),
      .rsp_need_fill   (rsp_need_fill),
      .rsp_hit         (rsp_hit)
   );

   always #10 clock = ~clock;

   function automatic answer_type lookup_tag_store(cache_op_type op,
                                                   logic [SECTOR_W-1:0] sector,
                                                   logic [COUNT_W-1:0] count_in,
                                                   logic [SLOT_W-1:0] failed_slot);
      answer_type answer;
      logic [COUNT_W-1:0] run_len;
      int i;
      int victim;
      bit have_victim;
      answer = '0;
      if (op == OP_FILL_FAILED) begin
         if (failed_slot < SLOTS) begin
            mirror_tag[failed_slot]  = '0;
            mirror_uses[failed_slot] = '0;
            mirror_len[failed_slot]  = '0;
         end
         answer.slot = failed_slot;
         fill_reports++;
         return answer;
      end
      if (count_in == 0)
         run_len = COUNT_W'(1);
      else if (count_in > MAX_RUN)
         run_len = COUNT_W'(MAX_RUN);
      else
         run_len = count_in;
      victim = 0;
      have_victim = 1'b0;
      for (i = 0; i < SLOTS; i++) begin
         if (mirror_tag[i] == sector) begin
            if (mirror_uses[i] != USES_MAX)
               mirror_uses[i] = mirror_uses[i] + 1'b1;
            answer.slot = i[SLOT_W-1:0];
            answer.hit  = 1'b1;
            if (mirror_len[i] >= run_len) begin
               full_hits++;
            end else begin
               mirror_len[i] = run_len;
               answer.need_fill = 1'b1;
               short_hits++;
            end
            return answer;
         end
         if (!have_victim || mirror_uses[victim] > mirror_uses[i]) begin
            victim = i;
            have_victim = 1'b1;
         end
         if (mirror_uses[victim] == 0)
            break;
      end
      mirror_tag[victim]  = sector;
      mirror_uses[victim] = USES_W'(1);
      mirror_len[victim]  = run_len;
      answer.slot      = victim[SLOT_W-1:0];
      answer.need_fill = 1'b1;
      misses++;
      return answer;
   endfunction

   // Presents one transaction after a gap and holds it until the block takes it.
   task automatic issue_step(cache_op_type op, logic [SECTOR_W-1:0] sector,
                             logic [COUNT_W-1:0] count_in, logic [SLOT_W-1:0] failed_slot,
                             int gap, bit typed, answer_type typed_answer);
      answer_type predicted;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_operation   <= op;
      req_sector      <= sector;
      req_count       <= count_in;
      req_failed_slot <= failed_slot;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = lookup_tag_store(op, sector, count_in, failed_slot);
      pending_answers.push_back(typed ? typed_answer : predicted);
   endtask

   always @(posedge clock) begin : answer_check
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("unexpected answer: slot %0d need_fill %b hit %b",
                        rsp_slot, rsp_need_fill, rsp_hit);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_slot !== want.slot || rsp_need_fill !== want.need_fill
                || rsp_hit !== want.hit) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("answer %0d: expected slot/fill/hit %0d/%b/%b, got %0d/%b/%b",
                           answers_checked, want.slot, want.need_fill, want.hit,
                           rsp_slot, rsp_need_fill, rsp_hit);
            end
            answers_checked++;
         end
      end
   end

   initial begin
      int i;
      int n;
      int gap_cap;
      int pick;
      cache_op_type op;
      logic [SECTOR_W-1:0] sector;
      logic [COUNT_W-1:0] count_in;

      reset           = 1'b1;
      start           = 1'b0;
      req_operation   = OP_LOOKUP;
      req_sector      = '0;
      req_count       = '0;
      req_failed_slot = '0;
      for (i = 0; i < SLOTS; i++) begin
         mirror_tag[i]  = '0;
         mirror_uses[i] = '0;
         mirror_len[i]  = '0;
      end
      for (i = 0; i < POOL_SIZE; i++)
         sector_pool[i] = $urandom;
      sector_pool[0] = '0;
      sector_pool[1] = '1;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i])
         issue_step(directed_steps[i].op, directed_steps[i].sector, directed_steps[i].count,
                    directed_steps[i].failed_slot, $urandom_range(0, 9),
                    directed_steps[i].typed, directed_steps[i].answer);

      // Clear slot 0 and hammer sector 0 back to back so its use count climbs far
      // above the rest; the following miss must not pick slot 0.
      issue_step(OP_FILL_FAILED, $urandom, COUNT_W'($urandom), 4'd0, $urandom_range(0, 9),
                 1'b0, '0);
      for (n = 0; n < REPEAT_HITS; n++)
         issue_step(OP_LOOKUP, '0, 8'd1, SLOT_W'($urandom), 0, 1'b0, '0);
      issue_step(OP_LOOKUP, 32'hDEAD_BEEF, 8'd16, 4'd0, 0, 1'b0, '0);

      gap_cap = 9;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 50 == 0)
            gap_cap = ($urandom_range(0, 3) == 0) ? 0 : 9;
         op = ($urandom_range(0, 99) < 12) ? OP_FILL_FAILED : OP_LOOKUP;
         pick = $urandom_range(0, 99);
         if (pick < 75)
            sector = sector_pool[$urandom_range(0, POOL_SIZE - 1)];
         else if (pick < 90)
            sector = $urandom;
         else
            sector = '0;
         pick = $urandom_range(0, 9);
         if (pick == 0)
            count_in = '0;
         else if (pick == 1)
            count_in = COUNT_W'($urandom_range(MAX_RUN + 1, 255));
         else
            count_in = COUNT_W'($urandom_range(1, MAX_RUN));
         issue_step(op, sector, count_in, SLOT_W'($urandom), $urandom_range(0, gap_cap),
                    1'b0, '0);
      end
      start <= 1'b0;

      while (pending_answers.size() != 0) @(posedge clock);
      repeat (SLOTS + 4) @(posedge clock);

      $display("Checked %0d answers: %0d full hits, %0d short hits, %0d misses,",
               answers_checked, full_hits, short_hits, misses);
      $display("%0d fill-failed reports, and a run of %0d back-to-back hits on one slot.",
               fill_reports, REPEAT_HITS);
      if (mismatch_count == 0) begin
         $display("sector_buffer_cache_lfu: match");
      end else begin
         $display("sector_buffer_cache_lfu: mismatch");
      end
      $finish;
   end

   initial begin
      #100_000_000;
      $display("Timed out with %0d answers still outstanding.", pending_answers.size());
      $display("sector_buffer_cache_lfu: mismatch");
      $finish;
   end

endmodule
